/* rtl/rps_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the reference-counted page store.
// No dependencies; every other file imports this package.
package rps_pkg;

    localparam int DEF_NUM_SLOTS = 16;
    localparam int DEF_PAGE_SIZE = 4096;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 16;
    localparam int OFFSET_W = 16;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int REFS_W   = 16;
    localparam int BYTE_W   = 8;

    localparam logic [ID_W-1:0]   ID_LAST  = '1;
    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC      = 3'd0,
        CMD_ADD_REF    = 3'd1,
        CMD_DROP_REF   = 3'd2,
        CMD_READ_BYTE  = 3'd3,
        CMD_READ_WORD  = 3'd4,
        CMD_WRITE_BYTE = 3'd5,
        CMD_WRITE_WORD = 3'd6,
        CMD_QUERY      = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_PAGE_FAULT   = 3'd1,
        ST_SEG_FAULT    = 3'd2,
        ST_NO_SLOT      = 3'd3,
        ST_IDS_EXHAUSTED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CLEAR,
        S_MEM,
        S_TAIL,
        S_DONE
    } state_t;

endpackage

/* rtl/rps_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the page store: command words in,
// result words out. Depends on rps_pkg for field widths.
interface rps_req_if import rps_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     page_id;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, cmd, page_id, offset, write_data, input ready);
    modport sink   (input valid, cmd, page_id, offset, write_data, output ready);
endinterface

interface rps_rsp_if import rps_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;
    logic [ID_W-1:0]     alloc_id;
    logic [REFS_W-1:0]   ref_now;

    modport source (output valid, status, read_data, alloc_id, ref_now, input ready);
    modport sink   (input valid, status, read_data, alloc_id, ref_now, output ready);
endinterface

/* rtl/refcounted_page_store.sv */
`timescale 1ns / 1ps
// Reference-counted page store: slot table, page memory and command sequencer.
// Depends on rps_pkg and the channel interfaces in rps_if.sv.
//
// Channel   Dir   Handshake      Payload
// req       in    valid/ready    cmd, page_id, offset, write_data
// rsp       out   valid/ready    status, read_data, alloc_id, ref_now
// cfg       in    cfg_we only    cfg_wdata = initial_refs
//
// Sequence: the slot search visits one slot per cycle; allocate then clears the
// page one byte per cycle. Byte and word accesses step through their bytes on
// the single memory port, and reads add a tail state for the last byte.
// The done state loads the result register; the next word is taken in the idle
// state that follows it.
// Reset clears the slot valid bits and the id counter at once; no sweep is run.
// A stalled result only holds off the finish of the following command.
module refcounted_page_store import rps_pkg::*; #(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int PAGE_SIZE = DEF_PAGE_SIZE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [REFS_W-1:0] cfg_wdata,
    rps_req_if.sink           req,
    rps_rsp_if.source         rsp
);

    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int POFF_W    = $clog2(PAGE_SIZE);
    localparam int MEM_DEPTH = NUM_SLOTS * PAGE_SIZE;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int BOUND_W   = OFFSET_W + 1;

    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [POFF_W-1:0]  POFF_LAST = POFF_W'(PAGE_SIZE - 1);
    localparam logic [BOUND_W-1:0] BOUND     = BOUND_W'(PAGE_SIZE);

    // Control state
    state_t                state_reg, state_next;
    logic [NUM_SLOTS-1:0]  slot_valid_reg;
    logic [ID_W-1:0]       next_id_reg;
    logic                  ids_used_up_reg;
    logic [REFS_W-1:0]     initial_refs_reg;
    logic                  rsp_valid_reg;
    logic                  rd_pend_reg;

    // Slot table payload and page memory
    logic [ID_W-1:0]       slot_page_id_reg [NUM_SLOTS];
    logic [REFS_W-1:0]     slot_refs_reg    [NUM_SLOTS];
    logic [BYTE_W-1:0]     page_mem         [MEM_DEPTH];
    logic [BYTE_W-1:0]     mem_rdata_reg;

    // Command context
    cmd_t                  cmd_reg;
    logic [ID_W-1:0]       pid_reg;
    logic [POFF_W-1:0]     ofs_reg;
    logic                  in_range_reg;
    logic [1:0]            beats_reg;
    logic [DATA_W-1:0]     wshift_reg;
    logic [DATA_W-1:0]     acc_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [ADDR_W-1:0]     base_reg;
    status_t               status_reg;
    logic [ID_W-1:0]       newid_reg;
    logic [REFS_W-1:0]     refs_reg;

    // Result register
    logic [STATUS_W-1:0]   rsp_status_reg;
    logic [DATA_W-1:0]     rsp_rdata_reg;
    logic [ID_W-1:0]       rsp_newid_reg;
    logic [REFS_W-1:0]     rsp_refs_reg;

    // Sequencer outputs
    logic                  req_ready;
    logic                  mem_we;
    logic [BYTE_W-1:0]     mem_wdata;
    logic [ADDR_W-1:0]     mem_addr;
    logic                  load_rsp;

    logic                  accept;
    logic                  is_alloc;
    logic                  is_read;
    logic                  is_mem_cmd;
    logic                  slot_hit;
    logic                  slot_last;
    logic [REFS_W-1:0]     cur_refs;
    logic [REFS_W-1:0]     dec_refs;
    cmd_t                  req_cmd;
    logic                  req_word;
    logic                  req_byte_ok;
    logic                  req_word_ok;

    assign req_cmd   = cmd_t'(req.cmd);
    assign accept    = req.valid && req_ready;
    assign is_alloc  = (cmd_reg == CMD_ALLOC);
    assign is_read   = (cmd_reg == CMD_READ_BYTE) || (cmd_reg == CMD_READ_WORD);
    assign is_mem_cmd = (cmd_reg == CMD_READ_BYTE) || (cmd_reg == CMD_READ_WORD) ||
                        (cmd_reg == CMD_WRITE_BYTE) || (cmd_reg == CMD_WRITE_WORD);
    assign slot_last = (idx_reg == SLOT_LAST);
    assign slot_hit  = is_alloc ? !slot_valid_reg[idx_reg]
                                : (slot_valid_reg[idx_reg] &&
                                   (slot_page_id_reg[idx_reg] == pid_reg));
    assign cur_refs  = slot_refs_reg[idx_reg];
    assign dec_refs  = (cur_refs != '0) ? (cur_refs - REFS_W'(1)) : '0;

    assign req_word    = (req_cmd == CMD_READ_WORD) || (req_cmd == CMD_WRITE_WORD);
    assign req_byte_ok = ({1'b0, req.offset} < BOUND);
    assign req_word_ok = (({1'b0, req.offset} + BOUND_W'(3)) < BOUND);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((req_cmd == CMD_ALLOC) && ids_used_up_reg)
                        state_next = S_DONE;
                    else
                        state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (slot_hit)
                begin
                    if (is_alloc)
                        state_next = S_CLEAR;
                    else if (is_mem_cmd && in_range_reg)
                        state_next = S_MEM;
                    else
                        state_next = S_DONE;
                end
                else if (slot_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR:
            begin
                if (ofs_reg == POFF_LAST)
                    state_next = S_DONE;
            end
            S_MEM:
            begin
                if (beats_reg == 2'd0)
                    state_next = is_read ? S_TAIL : S_DONE;
            end
            S_TAIL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req_ready = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = wshift_reg[DATA_W-1 -: BYTE_W];
        load_rsp  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            S_MEM:
            begin
                mem_we = !is_read;
            end
            S_DONE:
            begin
                load_rsp = !rsp_valid_reg || rsp.ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign mem_addr = base_reg + ADDR_W'(ofs_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            page_mem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= page_mem[mem_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            slot_valid_reg   <= '0;
            next_id_reg      <= '0;
            ids_used_up_reg  <= 1'b0;
            initial_refs_reg <= '0;
            rsp_valid_reg    <= 1'b0;
            rd_pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == S_MEM) && is_read;
            if (cfg_we)
                initial_refs_reg <= cfg_wdata;
            if (load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
            if ((state_reg == S_SEARCH) && slot_hit)
            begin
                if (is_alloc)
                begin
                    slot_valid_reg[idx_reg] <= 1'b1;
                    next_id_reg             <= next_id_reg + ID_W'(1);
                    if (next_id_reg == ID_LAST)
                        ids_used_up_reg <= 1'b1;
                end
                else if ((cmd_reg == CMD_DROP_REF) && (dec_refs == '0))
                begin
                    slot_valid_reg[idx_reg] <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= req_cmd;
            pid_reg      <= req.page_id;
            ofs_reg      <= req.offset[POFF_W-1:0];
            in_range_reg <= req_word ? req_word_ok : req_byte_ok;
            beats_reg    <= req_word ? 2'd3 : 2'd0;
            wshift_reg   <= req_word ? req.write_data
                                     : {req.write_data[BYTE_W-1:0], {(DATA_W-BYTE_W){1'b0}}};
            acc_reg      <= '0;
            idx_reg      <= '0;
            status_reg   <= ((req_cmd == CMD_ALLOC) && ids_used_up_reg) ? ST_IDS_EXHAUSTED
                                                                       : ST_OK;
            newid_reg    <= '0;
            refs_reg     <= '0;
        end

        if (state_reg == S_SEARCH)
        begin
            if (slot_hit)
            begin
                base_reg <= ADDR_W'(idx_reg) * ADDR_W'(PAGE_SIZE);
                unique case (cmd_reg) inside
                    CMD_ALLOC:
                    begin
                        slot_page_id_reg[idx_reg] <= next_id_reg;
                        slot_refs_reg[idx_reg]    <= initial_refs_reg;
                        newid_reg                 <= next_id_reg;
                        refs_reg                  <= initial_refs_reg;
                        ofs_reg                   <= '0;
                    end
                    CMD_ADD_REF:
                    begin
                        if (cur_refs != REFS_MAX)
                        begin
                            slot_refs_reg[idx_reg] <= cur_refs + REFS_W'(1);
                            refs_reg               <= cur_refs + REFS_W'(1);
                        end
                        else
                        begin
                            refs_reg <= cur_refs;
                        end
                    end
                    CMD_DROP_REF:
                    begin
                        slot_refs_reg[idx_reg] <= dec_refs;
                        refs_reg               <= dec_refs;
                    end
                    CMD_QUERY:
                    begin
                        refs_reg <= cur_refs;
                    end
                    CMD_READ_BYTE, CMD_READ_WORD, CMD_WRITE_BYTE, CMD_WRITE_WORD:
                    begin
                        if (in_range_reg)
                            refs_reg <= cur_refs;
                        else
                            status_reg <= ST_SEG_FAULT;
                    end
                    default:
                    begin
                        refs_reg <= cur_refs;
                    end
                endcase
            end
            else if (slot_last)
            begin
                status_reg <= is_alloc ? ST_NO_SLOT : ST_PAGE_FAULT;
            end
            else
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
        end

        if (state_reg == S_CLEAR)
            ofs_reg <= ofs_reg + POFF_W'(1);

        if (state_reg == S_MEM)
        begin
            wshift_reg <= {wshift_reg[DATA_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            if (beats_reg != 2'd0)
            begin
                beats_reg <= beats_reg - 2'd1;
                ofs_reg   <= ofs_reg + POFF_W'(1);
            end
        end

        // Each read issued in the previous cycle returns its byte now, most
        // significant byte first.
        if (rd_pend_reg)
            acc_reg <= {acc_reg[DATA_W-BYTE_W-1:0], mem_rdata_reg};

        if (load_rsp)
        begin
            rsp_status_reg <= status_reg;
            rsp_rdata_reg  <= acc_reg;
            rsp_newid_reg  <= newid_reg;
            rsp_refs_reg   <= refs_reg;
        end
    end

    assign req.ready     = req_ready;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.read_data = rsp_rdata_reg;
    assign rsp.alloc_id  = rsp_newid_reg;
    assign rsp.ref_now   = rsp_refs_reg;

    // The page being cleared must already be marked live.
    a_clear_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> slot_valid_reg[idx_reg])
        else $error("page clear runs on a free slot");

    // Once the last id is handed out the counter has wrapped to zero.
    a_ids_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        ids_used_up_reg |-> (next_id_reg == '0))
        else $error("id counter moved after ids ran out");

    // The page memory is only written by a clear or an in-range write.
    a_mem_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_CLEAR) ||
                    ((state_reg == S_MEM) && in_range_reg && !is_read)))
        else $error("page memory written outside a clear or write");

    // A result is loaded only when the result register is free or being drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> (rsp_status_reg == $past(rsp_status_reg)))
        else $error("pending result overwritten");

endmodule

/* test/refcounted_page_store_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_page_store: drives command words, predicts
// each result word from a local model of the slot table and pages, and compares.
// Depends on rps_pkg, the channel interfaces in rps_if.sv and the block itself.
module refcounted_page_store_tb;
    import rps_pkg::*;

    localparam int NUM_SLOTS = DEF_NUM_SLOTS;
    localparam int PAGE_SIZE = DEF_PAGE_SIZE;
    localparam int PHASE_ITEMS = 258;

    typedef struct {
        status_t             status;
        logic [DATA_W-1:0]   read_data;
        logic [ID_W-1:0]     alloc_id;
        logic [REFS_W-1:0]   ref_now;
    } page_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REFS_W-1:0] cfg_wdata;

    rps_req_if req_ch ();
    rps_rsp_if rsp_ch ();

    refcounted_page_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Local copy of the page store state.
    logic                live      [NUM_SLOTS];
    logic [ID_W-1:0]     live_id   [NUM_SLOTS];
    logic [REFS_W-1:0]   live_refs [NUM_SLOTS];
    logic [BYTE_W-1:0]   page_mem  [NUM_SLOTS*PAGE_SIZE];
    logic [ID_W-1:0]     id_next;
    logic                ids_spent;
    logic [REFS_W-1:0]   refs_on_alloc;

    page_result_t expected_results [$];
    int mismatches = 0;
    int send_idle_pct = 23;
    int recv_idle_pct = 66;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(64'd60_000_000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic page_result_t predict_page_cmd(input cmd_t c,
                                                      input logic [ID_W-1:0] pid,
                                                      input logic [OFFSET_W-1:0] off,
                                                      input logic [DATA_W-1:0] wd);
        page_result_t res;
        int slot;
        int base;
        res.status    = ST_OK;
        res.read_data = '0;
        res.alloc_id  = '0;
        res.ref_now   = '0;
        slot = -1;
        if (c == CMD_ALLOC)
        begin
            // Exhausted ids are reported ahead of a full pool.
            if (ids_spent)
                res.status = ST_IDS_EXHAUSTED;
            else
            begin
                for (int i = NUM_SLOTS - 1; i >= 0; i--)
                    if (!live[i])
                        slot = i;
                if (slot < 0)
                    res.status = ST_NO_SLOT;
                else
                begin
                    live[slot]      = 1'b1;
                    live_id[slot]   = id_next;
                    live_refs[slot] = refs_on_alloc;
                    for (int b = 0; b < PAGE_SIZE; b++)
                        page_mem[slot*PAGE_SIZE + b] = '0;
                    res.alloc_id = id_next;
                    res.ref_now  = refs_on_alloc;
                    if (id_next == ID_LAST)
                        ids_spent = 1'b1;
                    id_next = id_next + ID_W'(1);
                end
            end
            return res;
        end
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
            if (live[i] && live_id[i] == pid)
                slot = i;
        if (slot < 0)
        begin
            res.status = ST_PAGE_FAULT;
            return res;
        end
        base = slot*PAGE_SIZE + int'(off);
        case (c) inside
            CMD_ADD_REF:
            begin
                if (live_refs[slot] != REFS_MAX)
                    live_refs[slot] = live_refs[slot] + REFS_W'(1);
                res.ref_now = live_refs[slot];
            end
            CMD_DROP_REF:
            begin
                // A drop at zero frees the page rather than wrapping the count.
                if (live_refs[slot] != '0)
                    live_refs[slot] = live_refs[slot] - REFS_W'(1);
                if (live_refs[slot] == '0)
                    live[slot] = 1'b0;
                res.ref_now = live_refs[slot];
            end
            CMD_QUERY:
                res.ref_now = live_refs[slot];
            CMD_READ_BYTE, CMD_WRITE_BYTE:
            begin
                if (int'(off) >= PAGE_SIZE)
                    res.status = ST_SEG_FAULT;
                else
                begin
                    if (c == CMD_READ_BYTE)
                        res.read_data = {24'b0, page_mem[base]};
                    else
                        page_mem[base] = wd[7:0];
                    res.ref_now = live_refs[slot];
                end
            end
            default:
            begin
                if (int'(off) + 3 >= PAGE_SIZE)
                    res.status = ST_SEG_FAULT;
                else
                begin
                    if (c == CMD_READ_WORD)
                        res.read_data = {page_mem[base], page_mem[base + 1],
                                         page_mem[base + 2], page_mem[base + 3]};
                    else
                    begin
                        page_mem[base]     = wd[31:24];
                        page_mem[base + 1] = wd[23:16];
                        page_mem[base + 2] = wd[15:8];
                        page_mem[base + 3] = wd[7:0];
                    end
                    res.ref_now = live_refs[slot];
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [ID_W-1:0] pick_live_id();
        int live_slots [$];
        for (int i = 0; i < NUM_SLOTS; i++)
            if (live[i])
                live_slots.push_back(i);
        if (live_slots.size() == 0)
            return ID_W'($urandom_range(16'hFFFF));
        return live_id[live_slots[$urandom_range(live_slots.size() - 1)]];
    endfunction

    // Called at a rising edge; returns at the edge where the word was taken.
    // Valid is left high so that a following word can go out back to back.
    task automatic send_page_cmd(input cmd_t c, input logic [ID_W-1:0] pid,
                                 input logic [OFFSET_W-1:0] off,
                                 input logic [DATA_W-1:0] wd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= c;
        req_ch.page_id    <= pid;
        req_ch.offset     <= off;
        req_ch.write_data <= wd;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_results.push_back(predict_page_cmd(c, pid, off, wd));
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_initial_refs(input logic [REFS_W-1:0] value);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        refs_on_alloc = value;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
    endtask

    // Result sink with random back-pressure.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_result
        page_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with no command outstanding, status %0d",
                       rsp_ch.status);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(rsp_ch.status));
                if (rsp_ch.read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, rsp_ch.read_data);
                if (rsp_ch.alloc_id !== want.alloc_id)
                    report_mismatch("alloc_id", 32'(want.alloc_id),
                                    32'(rsp_ch.alloc_id));
                if (rsp_ch.ref_now !== want.ref_now)
                    report_mismatch("ref_now", 32'(want.ref_now), 32'(rsp_ch.ref_now));
            end
        end
    end

    // Mostly well-formed traffic on live pages, with some stray commands.
    task automatic run_mixed_traffic(input int n_items);
        int pick;
        int spot;
        int last;
        cmd_t c;
        logic [OFFSET_W-1:0] off;
        logic [ID_W-1:0] pid;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_page_cmd(CMD_ALLOC, ID_W'($urandom), OFFSET_W'($urandom), $urandom);
            else if (pick < 12)
                send_page_cmd(CMD_ADD_REF, pick_live_id(), OFFSET_W'($urandom), $urandom);
            else if (pick < 18)
                send_page_cmd(CMD_DROP_REF, pick_live_id(), OFFSET_W'($urandom), $urandom);
            else if (pick < 24)
                send_page_cmd(CMD_QUERY, pick_live_id(), OFFSET_W'($urandom), $urandom);
            else if (pick < 88)
            begin
                c = cmd_t'($urandom_range(int'(CMD_WRITE_WORD), int'(CMD_READ_BYTE)));
                last = (c == CMD_READ_WORD || c == CMD_WRITE_WORD) ?
                       PAGE_SIZE - 4 : PAGE_SIZE - 1;
                spot = $urandom_range(99);
                // A small hot window keeps reads landing on earlier writes.
                if (spot < 35)
                    off = OFFSET_W'($urandom_range(63));
                else if (spot < 55)
                    off = OFFSET_W'($urandom_range(last, last - 63));
                else if (spot < 75)
                    off = OFFSET_W'($urandom_range(last));
                else if (spot < 90)
                    off = OFFSET_W'(last + $urandom_range(4, 1));
                else
                    off = OFFSET_W'($urandom);
                send_page_cmd(c, pick_live_id(), off, $urandom);
            end
            else
            begin
                c = cmd_t'($urandom_range(7));
                if ($urandom_range(1))
                    pid = ID_W'($urandom);
                else
                    pid = id_next - ID_W'($urandom_range(8, 1));
                send_page_cmd(c, pid, OFFSET_W'($urandom), $urandom);
            end
        end
    endtask

    task automatic test_empty_pool_faults();
        send_page_cmd(CMD_QUERY, 16'h0000, 16'h0000, 32'h0000_0000);
        send_page_cmd(CMD_DROP_REF, 16'h0000, 16'h0000, 32'h0000_0000);
        send_page_cmd(CMD_READ_WORD, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        send_page_cmd(CMD_WRITE_BYTE, 16'h8000, 16'h0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_count_page();
        write_initial_refs('0);
        send_page_cmd(CMD_ALLOC, 16'h0000, 16'h0000, 32'h0000_0000);
        send_page_cmd(CMD_QUERY, 16'h0000, 16'h0000, 32'h0000_0000);
        send_page_cmd(CMD_DROP_REF, 16'h0000, 16'h0000, 32'h0000_0000);
        send_page_cmd(CMD_QUERY, 16'h0000, 16'h0000, 32'h0000_0000);
    endtask

    task automatic test_count_saturation();
        write_initial_refs(REFS_MAX);
        send_page_cmd(CMD_ALLOC, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_page_cmd(CMD_ADD_REF, 16'h0001, 16'h0000, 32'h0000_0000);
        send_page_cmd(CMD_DROP_REF, 16'h0001, 16'h0000, 32'h0000_0000);
        send_page_cmd(CMD_ADD_REF, 16'h0001, 16'h0000, 32'h0000_0000);
    endtask

    // Page 1 is live with a saturated count from the previous test.
    task automatic test_access_bounds();
        send_page_cmd(CMD_READ_WORD, 16'h0001, 16'd100, 32'h0000_0000);
        send_page_cmd(CMD_WRITE_WORD, 16'h0001, 16'd0, 32'h0102_0304);
        send_page_cmd(CMD_READ_BYTE, 16'h0001, 16'd0, 32'h0000_0000);
        send_page_cmd(CMD_READ_BYTE, 16'h0001, 16'd3, 32'h0000_0000);
        send_page_cmd(CMD_READ_WORD, 16'h0001, 16'd0, 32'h0000_0000);
        send_page_cmd(CMD_WRITE_BYTE, 16'h0001, 16'(PAGE_SIZE - 1), 32'hFFFF_FFAB);
        send_page_cmd(CMD_READ_WORD, 16'h0001, 16'(PAGE_SIZE - 4), 32'h0000_0000);
        send_page_cmd(CMD_READ_WORD, 16'h0001, 16'(PAGE_SIZE - 3), 32'h0000_0000);
        send_page_cmd(CMD_WRITE_WORD, 16'h0001, 16'(PAGE_SIZE - 1), 32'hFFFF_FFFF);
        send_page_cmd(CMD_READ_BYTE, 16'h0001, 16'(PAGE_SIZE), 32'h0000_0000);
        send_page_cmd(CMD_WRITE_BYTE, 16'h0001, 16'hFFFF, 32'hFFFF_FFFF);
        // Page 0 is gone: the page fault must win over the bad offset.
        send_page_cmd(CMD_READ_WORD, 16'h0000, 16'hFFFF, 32'h0000_0000);
    endtask

    task automatic test_traffic_receiver_stalls();
        send_idle_pct = 23;
        recv_idle_pct = 66;
        write_initial_refs(16'd1);
        run_mixed_traffic(PHASE_ITEMS);
        write_initial_refs(16'd2);
        run_mixed_traffic(PHASE_ITEMS);
    endtask

    task automatic test_traffic_sender_gaps();
        send_idle_pct = 66;
        recv_idle_pct = 23;
        write_initial_refs('0);
        run_mixed_traffic(PHASE_ITEMS);
        write_initial_refs(REFS_W'($urandom_range(7, 3)));
        run_mixed_traffic(PHASE_ITEMS);
    endtask

    task automatic test_traffic_full_pool();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_initial_refs(16'd3);
        run_mixed_traffic(PHASE_ITEMS);
        // Pages allocated now never free, so the pool fills.
        write_initial_refs(REFS_MAX);
        repeat (NUM_SLOTS + 1)
            send_page_cmd(CMD_ALLOC, ID_W'($urandom), OFFSET_W'($urandom), $urandom);
        run_mixed_traffic(PHASE_ITEMS);
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_ALLOC;
        req_ch.page_id    <= '0;
        req_ch.offset     <= '0;
        req_ch.write_data <= '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            live[i] = 1'b0;
        id_next       = '0;
        ids_spent     = 1'b0;
        refs_on_alloc = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pool_faults();
        test_zero_count_page();
        test_count_saturation();
        test_access_bounds();
        test_traffic_receiver_stalls();
        test_traffic_sender_gaps();
        test_traffic_full_pool();

        wait_for_results();
        repeat (64) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
